FILE: hw/rtl/cgso_pkg.sv
// Shared types and constants for the CAN gateway speed override core.
package cgso_pkg;

   localparam int unsigned STARTUP_GRACE_MS_DEF = 15000;

   localparam logic [2:0] OP_RX_BUS0 = 3'd0;
   localparam logic [2:0] OP_RX_BUS1 = 3'd1;
   localparam logic [2:0] OP_TX_BUS0 = 3'd2;
   localparam logic [2:0] OP_TX_BUS1 = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   localparam logic [1:0] CSR_SPEED_FRAME_ID      = 2'd0;
   localparam logic [1:0] CSR_REAL_SPEED_FRAME_ID = 2'd1;
   localparam logic [1:0] CSR_SPEED_HOLD_MS       = 2'd2;
   localparam logic [1:0] CSR_ACTIVITY_TIMEOUT_MS = 2'd3;

   localparam logic [31:0] SPEED_FRAME_ID_RST      = 32'h0000_0201;
   localparam logic [31:0] REAL_SPEED_FRAME_ID_RST = 32'h0000_0737;
   localparam logic [15:0] SPEED_HOLD_MS_RST       = 16'd10000;
   localparam logic [14:0] ACTIVITY_TIMEOUT_MS_RST = 15'd500;

   localparam logic signed [15:0] AGE_MAX       = 16'sd32767;
   localparam logic [15:0]        SPEED_AGE_MAX = 16'hFFFF;

   localparam int unsigned NUM_AGES = 4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] frame_id;
      logic [3:0]  frame_dlc;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } req_item_type;

   typedef struct packed {
      logic        forward_valid;
      logic        forward_bus;
      logic [31:0] out_frame_id;
      logic [3:0]  out_dlc;
      logic [31:0] out_data_low;
      logic [31:0] out_data_high;
      logic        speed_substituted;
      logic        watchdog_kick;
   } rsp_item_type;

endpackage

FILE: hw/rtl/cgso_in_stage.sv
// Input register stage holding one accepted request.
module cgso_in_stage
   import cgso_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type push_item,
   input  logic         pop,
   output logic         full,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= push_item;
      end
   end

   assign full = valid_ff;
   assign item = item_ff;

endmodule

FILE: hw/rtl/cgso_engine.sv
// Gateway state, configuration registers and per-request forwarding logic.
module cgso_engine
   import cgso_pkg::*;
#(
   parameter int unsigned STARTUP_GRACE_MS = STARTUP_GRACE_MS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam logic signed [15:0] AGE_INIT =
      16'(-(STARTUP_GRACE_MS & 32'h7FFF));

   logic [31:0] speed_frame_id_ff;
   logic [31:0] real_speed_frame_id_ff;
   logic [15:0] speed_hold_ms_ff;
   logic [14:0] activity_timeout_ms_ff;

   logic signed [15:0] age_ff [NUM_AGES];
   logic signed [15:0] age_in [NUM_AGES];
   logic [15:0]        speed_age_ff, speed_age_in;
   logic [15:0]        held_speed_ff, held_speed_in;

   logic signed [15:0] timeout_s;
   logic               is_real, is_speed;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_frame_id_ff      <= SPEED_FRAME_ID_RST;
         real_speed_frame_id_ff <= REAL_SPEED_FRAME_ID_RST;
         speed_hold_ms_ff       <= SPEED_HOLD_MS_RST;
         activity_timeout_ms_ff <= ACTIVITY_TIMEOUT_MS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SPEED_FRAME_ID:      speed_frame_id_ff      <= csr_data;
            CSR_REAL_SPEED_FRAME_ID: real_speed_frame_id_ff <= csr_data;
            CSR_SPEED_HOLD_MS:       speed_hold_ms_ff       <= csr_data[15:0];
            CSR_ACTIVITY_TIMEOUT_MS: activity_timeout_ms_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   assign timeout_s = $signed({1'b0, activity_timeout_ms_ff});
   assign is_real   = (item.frame_id == real_speed_frame_id_ff);
   assign is_speed  = (item.frame_id == speed_frame_id_ff);

   always_comb begin
      age_in        = age_ff;
      speed_age_in  = speed_age_ff;
      held_speed_in = held_speed_ff;
      result        = '0;
      unique case (item.op)
         OP_RX_BUS0: begin
            age_in[0]                  = '0;
            result.forward_valid       = 1'b1;
            result.forward_bus         = 1'b1;
            result.out_frame_id        = item.frame_id;
            result.out_dlc             = item.frame_dlc;
            result.out_data_low        = item.data_low;
            result.out_data_high       = item.data_high;
         end
         OP_RX_BUS1: begin
            age_in[1] = '0;
            if (is_real && !is_speed) begin
               held_speed_in = item.data_low[15:0];
               speed_age_in  = '0;
            end else begin
               result.forward_valid = 1'b1;
               result.forward_bus   = 1'b0;
               result.out_frame_id  = item.frame_id;
               result.out_dlc       = item.frame_dlc;
               result.out_data_low  = item.data_low;
               result.out_data_high = item.data_high;
               if (is_speed && (speed_age_ff < speed_hold_ms_ff)) begin
                  result.out_data_low[15:0] = held_speed_ff;
                  result.speed_substituted  = 1'b1;
               end
            end
         end
         OP_TX_BUS0: age_in[2] = '0;
         OP_TX_BUS1: age_in[3] = '0;
         OP_TICK: begin
            result.watchdog_kick = 1'b1;
            for (int i = 0; i < NUM_AGES; i++) begin
               if (age_ff[i] < AGE_MAX) begin
                  age_in[i] = age_ff[i] + 16'sd1;
               end
               if (!(age_in[i] < timeout_s)) begin
                  result.watchdog_kick = 1'b0;
               end
            end
            if (speed_age_ff != SPEED_AGE_MAX) begin
               speed_age_in = speed_age_ff + 16'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AGES; i++) begin
            age_ff[i] <= AGE_INIT;
         end
         speed_age_ff  <= SPEED_AGE_MAX;
         held_speed_ff <= '0;
      end else if (advance) begin
         age_ff        <= age_in;
         speed_age_ff  <= speed_age_in;
         held_speed_ff <= held_speed_in;
      end
   end

endmodule

FILE: hw/rtl/cgso_out_stage.sv
// Result register driving the response stream.
module cgso_out_stage
   import cgso_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         rsp_ready,
   output logic         space,
   output logic         valid,
   output rsp_item_type item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

FILE: hw/rtl/can_gateway_speed_override_core.sv
// Two-bus CAN gateway core with speed word override and watchdog kick.
// A request is captured in the input register; its result, computed by
// single-pass logic, is held in the result register that drives the response.
// Throughput: one request per cycle while the response side does not stall;
// every request gives exactly one response.
// Reset (synchronous): configuration to defaults, activity ages to minus the
// startup grace, speed age expired, held speed zero, both stages empty.
module can_gateway_speed_override_core
   import cgso_pkg::*;
#(
   parameter int unsigned STARTUP_GRACE_MS = STARTUP_GRACE_MS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // frame_id, frame_dlc, data_low, data_high, zero pad
   input  logic [103:0]  req_tdata,
   // op
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_frame_id, out_dlc, out_data_low, out_data_high, zero pad
   output logic [103:0]  rsp_tdata,
   // forward_valid, forward_bus, speed_substituted, watchdog_kick
   output logic [3:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);

   req_item_type req_item, cur_item;
   rsp_item_type calc_item, rsp_item;
   logic         in_full, out_space, advance, req_fire;

   assign req_item.op        = req_tuser;
   assign req_item.frame_id  = req_tdata[31:0];
   assign req_item.frame_dlc = req_tdata[35:32];
   assign req_item.data_low  = req_tdata[67:36];
   assign req_item.data_high = req_tdata[99:68];

   assign advance    = in_full && out_space;
   assign req_tready = !in_full || out_space;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   cgso_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_item (req_item),
      .pop       (advance),
      .full      (in_full),
      .item      (cur_item)
   );

   cgso_engine #(
      .STARTUP_GRACE_MS (STARTUP_GRACE_MS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (advance),
      .item      (cur_item),
      .result    (calc_item)
   );

   cgso_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (calc_item),
      .rsp_ready (rsp_tready),
      .space     (out_space),
      .valid     (rsp_tvalid),
      .item      (rsp_item)
   );

   assign rsp_tdata = {4'b0000, rsp_item.out_data_high, rsp_item.out_data_low,
                       rsp_item.out_dlc, rsp_item.out_frame_id};
   assign rsp_tuser = {rsp_item.watchdog_kick, rsp_item.speed_substituted,
                       rsp_item.forward_bus, rsp_item.forward_valid};

   a_kick_not_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_item.watchdog_kick && rsp_item.forward_valid))
      else $error("kick together with a forwarded frame");

   a_sub_to_bus0: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.speed_substituted) |->
         (rsp_item.forward_valid && !rsp_item.forward_bus))
      else $error("substitution on a frame not forwarded to bus 0");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_full && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are held");

   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_full)
      else $error("accepted request lost from input stage");

endmodule
